### rtl/vrdm_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// vrdm_pkg: shared definitions for the dual mode video RAM port
// Command codes, register indexes, field widths, the mode 1 address
// scramble and the command bundle from controller to datapath.
// ----------------------------------------------------------------------------
package vrdm_pkg;

    // Store geometry.
    localparam int WORD_COUNT = 32768;
    localparam int IDX_W      = $clog2(WORD_COUNT);
    localparam int WORD_W     = 16;
    localparam int BYTE_W     = 8;
    localparam int ADDR_W     = 17;
    localparam int WADDR_W    = 16;
    localparam int OFFSET_W   = 9;
    localparam int CMD_W      = 2;

    // Stream word layout.
    localparam int S_TDATA_W  = 40;
    localparam int M_TDATA_W  = 48;

    // Configuration port.
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;

    localparam int DEF_SPRITE_WINDOW_WORDS = 320;

    typedef enum logic [CMD_W-1:0] {
        CMD_WORD_RD  = 2'd0,
        CMD_WORD_WR  = 2'd1,
        CMD_BYTE_RD  = 2'd2,
        CMD_BYTE_WR  = 2'd3
    } t_cmd;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_VRAM_MODE   = 1'd0,
        REG_SPRITE_BASE = 1'd1
    } t_reg_idx;

    // Controller to datapath commands.
    typedef struct packed {
        logic             accept;   // input word taken, start the memory read
        logic             commit;   // finish the item: write back, load output
        logic             clr_we;   // clearing pass writes zero
        logic [IDX_W-1:0] clr_addr; // clearing pass address
    } t_dp_cmd;

    // Mode 1 index: word bits 15:10 move down to 14:9, bits 8:1 stay,
    // and bit 9 becomes bit 0.
    function automatic logic [IDX_W-1:0] f_scramble(input logic [WADDR_W-1:0] w);
        f_scramble = {w[15:10], w[8:1], w[9]};
    endfunction

endpackage
`default_nettype wire

### rtl/vrdm_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// vrdm_ctrl: sequencing controller
// Runs the clearing pass after reset, then steps each word through an
// accept cycle and an execute cycle, and tracks the output register.
// ----------------------------------------------------------------------------
module vrdm_ctrl (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_s_tvalid,
    output logic                o_s_tready,
    output logic                o_m_tvalid,
    input  wire                 i_m_tready,
    output vrdm_pkg::t_dp_cmd   o_cmd
);

    typedef enum logic [2:0] {
        S_CLEAR = 3'b001,
        S_IDLE  = 3'b010,
        S_EXEC  = 3'b100
    } t_state;

    t_state                       r_state, n_state;
    logic [vrdm_pkg::IDX_W-1:0]   r_clr_cnt, n_clr_cnt;
    logic                         r_m_valid, n_m_valid;
    logic                         accept, commit, clr_last;

    assign clr_last = (r_clr_cnt == {vrdm_pkg::IDX_W{1'b1}});
    assign accept   = (r_state == S_IDLE) && i_s_tvalid;
    // The output slot must be free, or be emptied in this same cycle.
    assign commit   = (r_state == S_EXEC) && (!r_m_valid || i_m_tready);

    always_comb begin
        n_state   = r_state;
        n_clr_cnt = r_clr_cnt;
        unique case (r_state)
            S_CLEAR: begin
                n_clr_cnt = r_clr_cnt + 1'b1;
                if (clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (accept) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                if (commit) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

    always_comb begin
        if (commit) begin
            n_m_valid = 1'b1;
        end else if (i_m_tready) begin
            n_m_valid = 1'b0;
        end else begin
            n_m_valid = r_m_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_CLEAR;
            r_clr_cnt <= '0;
            r_m_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_clr_cnt <= n_clr_cnt;
            r_m_valid <= n_m_valid;
        end
    end

    assign o_s_tready     = (r_state == S_IDLE);
    assign o_m_tvalid     = r_m_valid;
    assign o_cmd.accept   = accept;
    assign o_cmd.commit   = commit;
    assign o_cmd.clr_we   = (r_state == S_CLEAR);
    assign o_cmd.clr_addr = r_clr_cnt;

endmodule
`default_nettype wire

### rtl/vrdm_dp.sv
`default_nettype none
// ----------------------------------------------------------------------------
// vrdm_dp: video RAM datapath
// Holds the word store, the configuration registers, the address and
// byte-lane logic, the sprite window compare and the output register.
// ----------------------------------------------------------------------------
module vrdm_dp #(
    parameter int SPRITE_WINDOW_WORDS = vrdm_pkg::DEF_SPRITE_WINDOW_WORDS
) (
    input  wire                                i_clk,
    input  wire                                i_rst_n,
    input  vrdm_pkg::t_dp_cmd                  i_cmd,
    input  wire                                i_cfg_we,
    input  wire [vrdm_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  wire [vrdm_pkg::CFG_DATA_W-1:0]     i_cfg_wdata,
    input  wire [vrdm_pkg::CMD_W-1:0]          i_in_cmd,
    input  wire [vrdm_pkg::ADDR_W-1:0]         i_in_address,
    input  wire [vrdm_pkg::WORD_W-1:0]         i_in_data,
    output logic [vrdm_pkg::WORD_W-1:0]        o_read_data,
    output logic                               o_sprite_update_valid,
    output logic [vrdm_pkg::OFFSET_W-1:0]      o_sprite_offset,
    output logic [vrdm_pkg::WORD_W-1:0]        o_sprite_word
);

    localparam int WORD_W  = vrdm_pkg::WORD_W;
    localparam int BYTE_W  = vrdm_pkg::BYTE_W;
    localparam int WADDR_W = vrdm_pkg::WADDR_W;
    localparam int IDX_W   = vrdm_pkg::IDX_W;

    logic [WORD_W-1:0]           r_video_words [vrdm_pkg::WORD_COUNT];
    logic [WORD_W-1:0]           r_rdata;

    // Configuration registers.
    logic                        r_vram_mode;
    logic [WADDR_W-1:0]          r_sprite_base;

    // Item captured at accept.
    vrdm_pkg::t_cmd              r_cmd;
    logic [WADDR_W-1:0]          r_w;
    logic [IDX_W-1:0]            r_idx;
    logic                        r_lo;
    logic [WORD_W-1:0]           r_data;

    // Output register.
    logic [WORD_W-1:0]           r_read_data;
    logic                        r_spr_valid;
    logic [vrdm_pkg::OFFSET_W-1:0] r_spr_offset;
    logic [WORD_W-1:0]           r_spr_word;

    logic [WADDR_W-1:0]          in_w;
    logic [IDX_W-1:0]            in_idx;
    logic [BYTE_W-1:0]           lane_byte;
    logic [WORD_W-1:0]           word_rd;
    logic [WORD_W-1:0]           wr_word;
    logic [WORD_W-1:0]           store_word;
    logic [WADDR_W:0]            diff;
    logic                        in_window;
    logic                        is_write;
    logic                        mem_we;
    logic [IDX_W-1:0]            mem_waddr;
    logic [WORD_W-1:0]           mem_wdata;
    logic [WORD_W-1:0]           n_read_data;

    // Byte commands use the byte address shifted down as word address.
    assign in_w   = i_in_cmd[1] ? i_in_address[WADDR_W:1] : i_in_address[WADDR_W-1:0];
    assign in_idx = r_vram_mode ? vrdm_pkg::f_scramble(in_w) : in_w[IDX_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vram_mode   <= 1'b0;
            r_sprite_base <= '0;
        end else if (i_cfg_we) begin
            unique case (vrdm_pkg::t_reg_idx'(i_cfg_index))
                vrdm_pkg::REG_VRAM_MODE:   r_vram_mode   <= i_cfg_wdata[0];
                vrdm_pkg::REG_SPRITE_BASE: r_sprite_base <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_cmd  <= vrdm_pkg::t_cmd'(i_in_cmd);
            r_w    <= in_w;
            r_idx  <= in_idx;
            r_lo   <= i_in_address[0];
            r_data <= i_in_data;
        end
    end

    // Word read as seen by the port: mode 1 repeats the selected lane.
    assign lane_byte = r_w[0] ? r_rdata[BYTE_W-1:0] : r_rdata[WORD_W-1:BYTE_W];
    assign word_rd   = r_vram_mode ? {lane_byte, lane_byte} : r_rdata;

    // Word handed to the write: a byte write merges into the word read.
    always_comb begin
        if (r_cmd == vrdm_pkg::CMD_BYTE_WR) begin
            wr_word = r_lo ? {word_rd[WORD_W-1:BYTE_W], r_data[BYTE_W-1:0]}
                           : {r_data[BYTE_W-1:0], word_rd[BYTE_W-1:0]};
        end else begin
            wr_word = r_data;
        end
    end

    // Mode 1 stores only the low byte of the write word into its lane.
    always_comb begin
        if (!r_vram_mode) begin
            store_word = wr_word;
        end else if (r_w[0]) begin
            store_word = {r_rdata[WORD_W-1:BYTE_W], wr_word[BYTE_W-1:0]};
        end else begin
            store_word = {wr_word[BYTE_W-1:0], r_rdata[BYTE_W-1:0]};
        end
    end

    always_comb begin
        case (r_cmd)
            vrdm_pkg::CMD_WORD_RD: n_read_data = word_rd;
            vrdm_pkg::CMD_BYTE_RD: n_read_data = {{BYTE_W{1'b0}},
                r_lo ? word_rd[BYTE_W-1:0] : word_rd[WORD_W-1:BYTE_W]};
            default:               n_read_data = '0;
        endcase
    end

    assign is_write  = (r_cmd == vrdm_pkg::CMD_WORD_WR) || (r_cmd == vrdm_pkg::CMD_BYTE_WR);

    // Window test: no borrow, and the distance is below the window size.
    assign diff      = {1'b0, r_w} - {1'b0, r_sprite_base};
    assign in_window = !diff[WADDR_W] &&
                       (diff[WADDR_W-1:0] <= WADDR_W'(SPRITE_WINDOW_WORDS - 1));

    assign mem_we    = i_cmd.clr_we || (i_cmd.commit && is_write);
    assign mem_waddr = i_cmd.clr_we ? i_cmd.clr_addr : r_idx;
    assign mem_wdata = i_cmd.clr_we ? '0 : store_word;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_video_words[mem_waddr] <= mem_wdata;
        end
        if (i_cmd.accept) begin
            r_rdata <= r_video_words[in_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            r_read_data  <= n_read_data;
            r_spr_valid  <= is_write && in_window;
            r_spr_offset <= (is_write && in_window) ? diff[vrdm_pkg::OFFSET_W-1:0] : '0;
            r_spr_word   <= (is_write && in_window) ? wr_word : '0;
        end
    end

    assign o_read_data           = r_read_data;
    assign o_sprite_update_valid = r_spr_valid;
    assign o_sprite_offset       = r_spr_offset;
    assign o_sprite_word         = r_spr_word;

endmodule
`default_nettype wire

### rtl/video_ram_dual_mode_port.sv
`default_nettype none
// ----------------------------------------------------------------------------
// video_ram_dual_mode_port: dual mode video RAM port
// A 32768 by 16-bit video store reached through word and byte commands,
// with direct and scrambled byte-lane addressing and forwarding of
// writes into the sprite attribute window.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Handshake              Carries
//  s_axis    in         tvalid/tready          one command word
//  m_axis    out        tvalid/tready          one result word per command
//  cfg       in         write enable only      vram_mode, sprite_table_base
//
// Each command has an accept step, reading the store at the decoded index,
// and an execute step, forming the result, writing a store word back for
// write commands and loading the output register; this read-then-write on
// the single store keeps one command in flight. After reset the store is
// cleared one word per cycle with o_s_tready low, while configuration
// writes are taken. A waiting result stalls only the execute step.
//
module video_ram_dual_mode_port #(
    parameter int SPRITE_WINDOW_WORDS = vrdm_pkg::DEF_SPRITE_WINDOW_WORDS
) (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,

    // Fields from bit 0 up: address[16:0], data[32:17], zero pad.
    input  wire [vrdm_pkg::S_TDATA_W-1:0]       i_s_tdata,
    // Fields from bit 0 up: cmd[1:0].
    input  wire [vrdm_pkg::CMD_W-1:0]           i_s_tuser,
    input  wire                                 i_s_tvalid,
    output logic                                o_s_tready,

    // Fields from bit 0 up: read_data[15:0], sprite_offset[24:16],
    // sprite_word[40:25], zero pad.
    output logic [vrdm_pkg::M_TDATA_W-1:0]      o_m_tdata,
    // Fields from bit 0 up: sprite_update_valid.
    output logic                                o_m_tuser,
    output logic                                o_m_tvalid,
    input  wire                                 i_m_tready,

    input  wire                                 i_cfg_we,
    input  wire [vrdm_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  wire [vrdm_pkg::CFG_DATA_W-1:0]      i_cfg_wdata
);

    localparam int ADDR_W   = vrdm_pkg::ADDR_W;
    localparam int WORD_W   = vrdm_pkg::WORD_W;
    localparam int OFFSET_W = vrdm_pkg::OFFSET_W;
    localparam int PAD_W    = vrdm_pkg::M_TDATA_W - 2 * WORD_W - OFFSET_W;

    vrdm_pkg::t_dp_cmd              w_cmd;
    logic [WORD_W-1:0]              read_data;
    logic                           spr_valid;
    logic [OFFSET_W-1:0]            spr_offset;
    logic [WORD_W-1:0]              spr_word;

    // The controller owns sequencing and the output valid flag.
    vrdm_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_cmd      (w_cmd)
    );

    // The datapath holds the store, configuration and the result payload.
    vrdm_dp #(
        .SPRITE_WINDOW_WORDS (SPRITE_WINDOW_WORDS)
    ) u_dp (
        .i_clk                 (i_clk),
        .i_rst_n               (i_rst_n),
        .i_cmd                 (w_cmd),
        .i_cfg_we              (i_cfg_we),
        .i_cfg_index           (i_cfg_index),
        .i_cfg_wdata           (i_cfg_wdata),
        .i_in_cmd              (i_s_tuser),
        .i_in_address          (i_s_tdata[ADDR_W-1:0]),
        .i_in_data             (i_s_tdata[ADDR_W+WORD_W-1:ADDR_W]),
        .o_read_data           (read_data),
        .o_sprite_update_valid (spr_valid),
        .o_sprite_offset       (spr_offset),
        .o_sprite_word         (spr_word)
    );

    assign o_m_tdata = {{PAD_W{1'b0}}, spr_word, spr_offset, read_data};
    assign o_m_tuser = spr_valid;

    // A finished item must never overwrite a result that is still waiting.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.commit |-> (!o_m_tvalid || i_m_tready))
        else $error("result register overwritten while full");

    // One item at a time: the port is closed in the cycle after an accept.
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready) |=> !o_s_tready)
        else $error("second word accepted while an item is in flight");

    // The clearing pass owns the write port and keeps the input closed.
    a_clear_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.clr_we |-> (!o_s_tready && !w_cmd.commit && !w_cmd.accept))
        else $error("item activity during the clearing pass");

    // Every commit raises the output valid in the next cycle.
    a_commit_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.commit |=> o_m_tvalid)
        else $error("committed result not presented");

endmodule
`default_nettype wire
